### hw/rtl/tcg_pkg.sv
package tcg_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 18;
  localparam int TAB_LEN       = 30;
  localparam int SQRT_STAGES   = 16;
  localparam int SQRT_ITERS    = 32 / SQRT_STAGES;
  localparam int CORDIC_LAT    = CORDIC_STAGES + 4;
  localparam int SIDE_DEPTH    = SQRT_STAGES + CORDIC_LAT;
  localparam int LATENCY       = 4 + SQRT_STAGES + CORDIC_LAT + 3;

  // cordic datapath widths
  localparam int NW = 41;
  localparam int CW = 44;
  localparam int ZW = 33;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [31:0] STEP_Q      = 32'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [32:0] ROUND_Q30   = 33'(1 << (29 - FRAC_BITS));

  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_SCALE_U  = 3'd1;
  localparam logic [2:0] REG_SCALE_V  = 3'd2;
  localparam logic [2:0] REG_OFFSET_U = 3'd3;
  localparam logic [2:0] REG_OFFSET_V = 3'd4;

  localparam logic [1:0] MODE_SPHERICAL = 2'd1;
  localparam logic [1:0] MODE_BOX       = 2'd2;

  typedef struct packed {
    logic               sph;
    logic [31:0]        ax;
    logic [31:0]        az;
    logic [31:0]        ay;
    logic               yneg;
    logic signed [32:0] cu;
    logic signed [32:0] cv;
  } tcg_side_t;

  typedef struct packed {
    logic [63:0] rad;
    logic [35:0] rem;
    logic [31:0] root;
  } tcg_sqrt_t;

  typedef struct packed {
    logic [NW-1:0] a;
    logic [NW-1:0] b;
  } tcg_pair_t;

  function automatic logic [31:0] atan_q30(input int idx);
    logic [31:0] r;
    case (idx)
      0: r = 32'd843314857;
      1: r = 32'd497837829;
      2: r = 32'd263043837;
      3: r = 32'd133525159;
      4: r = 32'd67021687;
      5: r = 32'd33543516;
      6: r = 32'd16775851;
      7: r = 32'd8388437;
      8: r = 32'd4194283;
      9: r = 32'd2097149;
      default: r = (idx < TAB_LEN) ? 32'(32'd1 << (30 - idx)) : 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    logic [32:0] n;
    n = -{v[31], v};
    return v[31] ? n[31:0] : v;
  endfunction

  function automatic logic [15:0] abs16(input logic [15:0] v);
    logic [16:0] n;
    n = -{v[15], v};
    return v[15] ? n[15:0] : v;
  endfunction

endpackage

### hw/rtl/tcg_isqrt.sv
module tcg_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [63:0] in_value,
  output logic        out_valid,
  output logic [31:0] out_root
);

  logic                v_r [tcg_pkg::SQRT_STAGES];
  tcg_pkg::tcg_sqrt_t  s_r [tcg_pkg::SQRT_STAGES];

  // restoring square root, two result bits per stage
  function automatic tcg_pkg::tcg_sqrt_t sqrt_step(input tcg_pkg::tcg_sqrt_t s);
    tcg_pkg::tcg_sqrt_t t;
    logic [35:0] trial;
    t = s;
    for (int k = 0; k < tcg_pkg::SQRT_ITERS; k++) begin
      t.rem = {t.rem[33:0], t.rad[63:62]};
      t.rad = {t.rad[61:0], 2'b00};
      trial = {2'b00, t.root, 2'b01};
      if (t.rem >= trial) begin
        t.rem  = t.rem - trial;
        t.root = {t.root[30:0], 1'b1};
      end else begin
        t.root = {t.root[30:0], 1'b0};
      end
    end
    return t;
  endfunction

  for (genvar g = 0; g < tcg_pkg::SQRT_STAGES; g++) begin : g_stage
    tcg_pkg::tcg_sqrt_t s_nxt;
    logic               v_nxt;
    if (g == 0) begin : g_first
      always_comb begin
        s_nxt = sqrt_step('{rad: in_value, rem: '0, root: '0});
        v_nxt = in_valid;
      end
    end else begin : g_rest
      always_comb begin
        s_nxt = sqrt_step(s_r[g-1]);
        v_nxt = v_r[g-1];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= v_nxt;
      end
      s_r[g] <= s_nxt;
    end
  end

  assign out_valid = v_r[tcg_pkg::SQRT_STAGES-1];
  assign out_root  = s_r[tcg_pkg::SQRT_STAGES-1].root;

endmodule

### hw/rtl/tcg_cordic.sv
module tcg_cordic (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [32:0] in_a,
  input  logic [32:0] in_b,
  output logic        out_valid,
  output logic [30:0] out_angle
);

  localparam int NW = tcg_pkg::NW;
  localparam int CW = tcg_pkg::CW;
  localparam int ZW = tcg_pkg::ZW;
  localparam int NS = tcg_pkg::CORDIC_STAGES;

  function automatic tcg_pkg::tcg_pair_t norm_shift(input tcg_pkg::tcg_pair_t p, input int k);
    tcg_pkg::tcg_pair_t t;
    t = p;
    if (((p.a | p.b) >> (NW - k)) == '0) begin
      t.a = p.a << k;
      t.b = p.b << k;
    end
    return t;
  endfunction

  logic               in_v_r, n1_v_r;
  tcg_pkg::tcg_pair_t in_p_r, n1_p_r;
  logic               in_za_r, in_zb_r, n1_za_r, n1_zb_r;
  tcg_pkg::tcg_pair_t n1_nxt, n2_nxt;

  logic                 v_r  [0:NS];
  logic                 za_r [0:NS];
  logic                 zb_r [0:NS];
  logic signed [CW-1:0] x_r  [0:NS];
  logic signed [CW-1:0] y_r  [0:NS];
  logic signed [ZW-1:0] z_r  [0:NS];

  logic        out_v_r;
  logic [30:0] out_angle_r;
  logic [30:0] angle_nxt;

  // coarse then fine normalization so the top operand lands in [2^40, 2^41)
  always_comb begin
    n1_nxt = norm_shift(norm_shift(norm_shift(in_p_r, 32), 16), 8);
    n2_nxt = norm_shift(norm_shift(norm_shift(n1_p_r, 4), 2), 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      n1_v_r <= 1'b0;
      v_r[0] <= 1'b0;
    end else begin
      in_v_r <= in_valid;
      n1_v_r <= in_v_r;
      v_r[0] <= n1_v_r;
    end
    in_p_r  <= '{a: NW'(in_a), b: NW'(in_b)};
    in_za_r <= (in_a == '0);
    in_zb_r <= (in_b == '0);
    n1_p_r  <= n1_nxt;
    n1_za_r <= in_za_r;
    n1_zb_r <= in_zb_r;
    x_r[0]  <= $signed(CW'(n2_nxt.a));
    y_r[0]  <= $signed(CW'(n2_nxt.b));
    z_r[0]  <= '0;
    za_r[0] <= n1_za_r;
    zb_r[0] <= n1_zb_r;
  end

  for (genvar i = 0; i < NS; i++) begin : g_iter
    logic signed [CW-1:0] x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;
    logic signed [ZW-1:0] step;
    always_comb begin
      step = $signed({1'b0, tcg_pkg::atan_q30(i)});
      if (!y_r[i][CW-1]) begin
        x_nxt = x_r[i] + (y_r[i] >>> i);
        y_nxt = y_r[i] - (x_r[i] >>> i);
        z_nxt = z_r[i] + step;
      end else begin
        x_nxt = x_r[i] - (y_r[i] >>> i);
        y_nxt = y_r[i] + (x_r[i] >>> i);
        z_nxt = z_r[i] - step;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
      x_r[i+1]  <= x_nxt;
      y_r[i+1]  <= y_nxt;
      z_r[i+1]  <= z_nxt;
      za_r[i+1] <= za_r[i];
      zb_r[i+1] <= zb_r[i];
    end
  end

  always_comb begin
    priority if (za_r[NS] && zb_r[NS]) begin
      angle_nxt = '0;
    end else if (za_r[NS]) begin
      angle_nxt = tcg_pkg::HALF_PI_Q30;
    end else if (z_r[NS][ZW-1]) begin
      angle_nxt = '0;
    end else if (z_r[NS] > $signed({2'b00, tcg_pkg::HALF_PI_Q30})) begin
      angle_nxt = tcg_pkg::HALF_PI_Q30;
    end else begin
      angle_nxt = z_r[NS][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= v_r[NS];
    end
    out_angle_r <= angle_nxt;
  end

  assign out_valid = out_v_r;
  assign out_angle = out_angle_r;

endmodule

### hw/rtl/tcg_map.sv
module tcg_map (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic signed [32:0] in_coord,
  input  logic signed [31:0] in_scale,
  input  logic signed [31:0] in_offset,
  output logic               out_valid,
  output logic [31:0]        out_coord,
  output logic               out_sat
);

  logic               prod_v_r, res_v_r;
  logic signed [64:0] prod_r;
  logic signed [64:0] shifted;
  logic signed [48:0] sum;
  logic [31:0]        coord_nxt, coord_r;
  logic               sat_nxt, sat_r;

  // floor shift back to coordinate format, then add and clamp
  always_comb begin
    shifted = prod_r >>> tcg_pkg::FRAC_BITS;
    sum     = $signed(shifted[48:0]) + 49'(in_offset);
    priority if (sum > 49'sd2147483647) begin
      coord_nxt = 32'h7fff_ffff;
      sat_nxt   = 1'b1;
    end else if (sum < -49'sd2147483648) begin
      coord_nxt = 32'h8000_0000;
      sat_nxt   = 1'b1;
    end else begin
      coord_nxt = sum[31:0];
      sat_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
      res_v_r  <= 1'b0;
    end else begin
      prod_v_r <= in_valid;
      res_v_r  <= prod_v_r;
    end
    prod_r  <= 65'(in_coord) * 65'(in_scale);
    coord_r <= coord_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_valid = res_v_r;
  assign out_coord = coord_r;
  assign out_sat   = sat_r;

endmodule

### hw/rtl/uv_texture_coordinate_generator.sv
// a start transfer reaches the out_valid strobe through the prep registers, the square root
// (16 stages), the 18-stage cordic and the pick and map registers
// throughput: one vertex per cycle, busy stays low and start may be high every cycle
// reset: synchronous, active low, clears the pipeline valid bits and restores
// mode 0, unit scales and zero offsets; results cannot be stalled by the receiver
module uv_texture_coordinate_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [15:0] in_normal_x,
  input  logic [15:0] in_normal_y,
  input  logic [15:0] in_normal_z,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        out_valid,
  output logic [31:0] out_u_coord,
  output logic [31:0] out_v_coord,
  output logic        out_saturated
);

  localparam int SQ = tcg_pkg::SQRT_STAGES;
  localparam int SD = tcg_pkg::SIDE_DEPTH;

  logic [1:0]         mode_r;
  logic signed [31:0] scale_u_r, scale_v_r, offset_u_r, offset_v_r;
  logic               cfg_wr;

  logic        s0_v_r;
  logic [31:0] x0_r, y0_r, z0_r;
  logic [15:0] nx0_r, ny0_r, nz0_r;

  tcg_pkg::tcg_side_t sb1_nxt, sb1_r, sb2_r, sb3_r;
  tcg_pkg::tcg_side_t sbd_r [SD];
  logic               s1_v_r, s2_v_r, s3_v_r;
  logic [63:0]        sqx_r, sqz_r, sum_r;

  logic [31:0] ax_raw, az_raw, xs, zs;
  logic [15:0] anx, any, anz;
  logic        near_pole;

  logic        rt_v;
  logic [31:0] rho;
  logic        cu_v, cv_v;
  logic [30:0] ang_u, ang_v;

  tcg_pkg::tcg_side_t sb_mid, sb_end;
  logic [32:0]        full_v, rnd_u, rnd_v;
  logic signed [32:0] pu_nxt, pv_nxt, pu_r, pv_r;
  logic               p_v_r;

  logic        mu_v, mv_v, su, sv;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 2'd0;
      scale_u_r  <= 32'sd65536;
      scale_v_r  <= 32'sd65536;
      offset_u_r <= '0;
      offset_v_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        tcg_pkg::REG_MODE:     mode_r     <= pwdata[1:0];
        tcg_pkg::REG_SCALE_U:  scale_u_r  <= pwdata;
        tcg_pkg::REG_SCALE_V:  scale_v_r  <= pwdata;
        tcg_pkg::REG_OFFSET_U: offset_u_r <= pwdata;
        tcg_pkg::REG_OFFSET_V: offset_v_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      tcg_pkg::REG_MODE:     prdata = {30'd0, mode_r};
      tcg_pkg::REG_SCALE_U:  prdata = scale_u_r;
      tcg_pkg::REG_SCALE_V:  prdata = scale_v_r;
      tcg_pkg::REG_OFFSET_U: prdata = offset_u_r;
      tcg_pkg::REG_OFFSET_V: prdata = offset_v_r;
      default:               prdata = '0;
    endcase
  end

  // operand prep: spherical clamp, magnitudes and box axis choice
  always_comb begin
    ax_raw    = tcg_pkg::abs32(x0_r);
    az_raw    = tcg_pkg::abs32(z0_r);
    anx       = tcg_pkg::abs16(nx0_r);
    any       = tcg_pkg::abs16(ny0_r);
    anz       = tcg_pkg::abs16(nz0_r);
    near_pole = (ax_raw < tcg_pkg::STEP_Q) && (az_raw < tcg_pkg::STEP_Q);
    xs        = near_pole ? tcg_pkg::STEP_Q : x0_r;
    zs        = near_pole ? tcg_pkg::STEP_Q : z0_r;
    sb1_nxt.sph  = (mode_r == tcg_pkg::MODE_SPHERICAL);
    sb1_nxt.ax   = tcg_pkg::abs32(xs);
    sb1_nxt.az   = tcg_pkg::abs32(zs);
    sb1_nxt.ay   = tcg_pkg::abs32(y0_r);
    sb1_nxt.yneg = y0_r[31];
    if (mode_r == tcg_pkg::MODE_BOX) begin
      priority if (anz > anx && anz > any) begin
        sb1_nxt.cu = $signed({1'b0, ax_raw});
        sb1_nxt.cv = $signed({1'b0, tcg_pkg::abs32(y0_r)});
      end else if (any > anx) begin
        sb1_nxt.cu = $signed({1'b0, ax_raw});
        sb1_nxt.cv = -$signed({1'b0, az_raw});
      end else begin
        sb1_nxt.cu = -$signed({1'b0, az_raw});
        sb1_nxt.cv = $signed({1'b0, tcg_pkg::abs32(y0_r)});
      end
    end else begin
      sb1_nxt.cu = $signed({x0_r[31], x0_r});
      sb1_nxt.cv = $signed({y0_r[31], y0_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s0_v_r <= start & ~busy;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
    x0_r  <= in_pos_x;
    y0_r  <= in_pos_y;
    z0_r  <= in_pos_z;
    nx0_r <= in_normal_x;
    ny0_r <= in_normal_y;
    nz0_r <= in_normal_z;
    sb1_r <= sb1_nxt;
    sqx_r <= 64'(sb1_r.ax) * 64'(sb1_r.ax);
    sqz_r <= 64'(sb1_r.az) * 64'(sb1_r.az);
    sb2_r <= sb1_r;
    sum_r <= sqx_r + sqz_r;
    sb3_r <= sb2_r;
  end

  tcg_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_v_r),
    .in_value  (sum_r),
    .out_valid (rt_v),
    .out_root  (rho)
  );

  // side data rides along the sqrt and cordic stages
  always_ff @(posedge clk) begin
    sbd_r[0] <= sb3_r;
    for (int k = 1; k < SD; k++) begin
      sbd_r[k] <= sbd_r[k-1];
    end
  end

  assign sb_mid = sbd_r[SQ-1];
  assign sb_end = sbd_r[SD-1];

  tcg_cordic u_cordic_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rt_v),
    .in_a      ({1'b0, sb_mid.az}),
    .in_b      ({1'b0, sb_mid.ax}),
    .out_valid (cu_v),
    .out_angle (ang_u)
  );

  tcg_cordic u_cordic_v (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rt_v),
    .in_a      ({1'b0, sb_mid.ay}),
    .in_b      ({1'b0, rho}),
    .out_valid (cv_v),
    .out_angle (ang_v)
  );

  // polar angle below the horizon is pi minus the mirrored angle
  always_comb begin
    full_v = sb_end.yneg ? (tcg_pkg::PI_Q30 - {2'b00, ang_v}) : {2'b00, ang_v};
    rnd_u  = ({2'b00, ang_u} + tcg_pkg::ROUND_Q30) >> (30 - tcg_pkg::FRAC_BITS);
    rnd_v  = (full_v + tcg_pkg::ROUND_Q30) >> (30 - tcg_pkg::FRAC_BITS);
    pu_nxt = sb_end.sph ? $signed(rnd_u) : sb_end.cu;
    pv_nxt = sb_end.sph ? $signed(rnd_v) : sb_end.cv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else begin
      p_v_r <= cu_v & cv_v;
    end
    pu_r <= pu_nxt;
    pv_r <= pv_nxt;
  end

  tcg_map u_map_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_v_r),
    .in_coord  (pu_r),
    .in_scale  (scale_u_r),
    .in_offset (offset_u_r),
    .out_valid (mu_v),
    .out_coord (out_u_coord),
    .out_sat   (su)
  );

  tcg_map u_map_v (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (p_v_r),
    .in_coord  (pv_r),
    .in_scale  (scale_v_r),
    .in_offset (offset_v_r),
    .out_valid (mv_v),
    .out_coord (out_v_coord),
    .out_sat   (sv)
  );

  assign out_valid     = mu_v & mv_v;
  assign out_saturated = su | sv;

endmodule

### hw/rtl/tcg_checker.sv
module tcg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_u_coord,
  input logic [31:0] out_v_coord,
  input logic        out_saturated
);

  // reset empties the pipeline
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // every result traces back to an earlier accepted start transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, tcg_pkg::LATENCY))
    else $error("result without a matching transfer");

  // a saturated result carries a clamped coordinate
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_u_coord == 32'h7fff_ffff || out_u_coord == 32'h8000_0000 ||
       out_v_coord == 32'h7fff_ffff || out_v_coord == 32'h8000_0000))
    else $error("saturation flag without clamped coordinate");

endmodule

bind uv_texture_coordinate_generator tcg_checker u_tcg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_u_coord   (out_u_coord),
  .out_v_coord   (out_v_coord),
  .out_saturated (out_saturated)
);

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_PLANAR     = 2'd0;
  localparam logic [1:0] MODE_PLANAR_ALT = 2'd3;
  localparam logic [2:0] REG_UNUSED      = 3'd5;
  localparam longint     NORM_LIMIT      = 64'sd1 << 40;
  localparam longint     STEP            = ((64'sd1 << tcg_pkg::FRAC_BITS) + 5) / 10;
  localparam int         IDLE_LIMIT      = 4000;

  typedef struct {
    logic [31:0] x, y, z;
    logic [15:0] nx, ny, nz;
  } vertex_t;

  typedef struct {
    logic [31:0] u, v;
    logic        sat;
  } uv_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [15:0] in_normal_x = '0, in_normal_y = '0, in_normal_z = '0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        out_valid;
  logic [31:0] out_u_coord, out_v_coord;
  logic        out_saturated;

  uv_texture_coordinate_generator u_top (.*);

  always #5 clk = ~clk;

  longint atan_tab [30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2};

  // mirror of the register file
  logic [1:0] mode_m = MODE_PLANAR;
  longint     su_m = 65536, sv_m = 65536, ou_m = 0, ov_m = 0;

  vertex_t pending_verts[$];
  uv_t     expected_uv[$];
  int      n_accepted = 0, n_popped = 0;
  int      n_errors = 0, idle_cycles = 0;

  function automatic bit [63:0] isqrt(bit [63:0] v);
    bit [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // atan(b / a) in q2.30, clamped to the first quadrant
  function automatic longint vec_atan(longint a, longint b);
    longint xr, yr, zr, dx, dy;
    if (a == 0 && b == 0) return 0;
    if (a == 0) return longint'(tcg_pkg::HALF_PI_Q30);
    while (a < NORM_LIMIT && b < NORM_LIMIT) begin
      a = a <<< 1;
      b = b <<< 1;
    end
    xr = a;
    yr = b;
    zr = 0;
    for (int i = 0; i < tcg_pkg::CORDIC_STAGES && i < 30; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (yr >= 0) begin
        xr += dx; yr -= dy; zr += atan_tab[i];
      end else begin
        xr -= dx; yr += dy; zr -= atan_tab[i];
      end
    end
    if (zr < 0) zr = 0;
    if (zr > longint'(tcg_pkg::HALF_PI_Q30)) zr = longint'(tcg_pkg::HALF_PI_Q30);
    return zr;
  endfunction

  function automatic logic [31:0] map_coord(longint c, longint s, longint o, inout bit sat);
    longint r;
    r = ((c * s) >>> tcg_pkg::FRAC_BITS) + o;
    if (r > 64'sd2147483647) begin
      sat = 1'b1;
      r = 64'sd2147483647;
    end else if (r < -64'sd2147483648) begin
      sat = 1'b1;
      r = -64'sd2147483648;
    end
    return r[31:0];
  endfunction

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic uv_t predict_uv(vertex_t vx);
    longint x, y, z, nx, ny, nz, cu, cv, ax, az, rho, b;
    bit     sat;
    uv_t    r;
    x = longint'($signed(vx.x));
    y = longint'($signed(vx.y));
    z = longint'($signed(vx.z));
    nx = iabs(longint'($signed(vx.nx)));
    ny = iabs(longint'($signed(vx.ny)));
    nz = iabs(longint'($signed(vx.nz)));
    sat = 1'b0;
    if (mode_m == tcg_pkg::MODE_SPHERICAL) begin
      // near the pole axis both x and z snap to one step
      if (iabs(x) < STEP && iabs(z) < STEP) begin
        x = STEP;
        z = STEP;
      end
      ax = iabs(x);
      az = iabs(z);
      rho = longint'(isqrt(64'(ax * ax) + 64'(az * az)));
      if (y >= 0) b = vec_atan(y, rho);
      else b = longint'(tcg_pkg::PI_Q30) - vec_atan(-y, rho);
      cu = (vec_atan(az, ax) + (64'sd1 << (29 - tcg_pkg::FRAC_BITS)))
           >>> (30 - tcg_pkg::FRAC_BITS);
      cv = (b + (64'sd1 << (29 - tcg_pkg::FRAC_BITS))) >>> (30 - tcg_pkg::FRAC_BITS);
    end else if (mode_m == tcg_pkg::MODE_BOX) begin
      if (nz > nx && nz > ny) begin
        cu = iabs(x); cv = iabs(y);
      end else if (ny > nx) begin
        cu = iabs(x); cv = -iabs(z);
      end else begin
        cu = -iabs(z); cv = iabs(y);
      end
    end else begin
      cu = x;
      cv = y;
    end
    r.u = map_coord(cu, su_m, ou_m, sat);
    r.v = map_coord(cv, sv_m, ov_m, sat);
    r.sat = sat;
    return r;
  endfunction

  // accept side, result check and watchdog
  always @(posedge clk) begin
    uv_t e;
    if (rst_n) begin
      if (start && !busy) begin
        expected_uv.push_back(predict_uv('{in_pos_x, in_pos_y, in_pos_z,
                                           in_normal_x, in_normal_y, in_normal_z}));
        n_accepted <= n_accepted + 1;
      end
      if (out_valid) begin
        if (expected_uv.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected result u=%h v=%h", out_u_coord, out_v_coord);
        end else begin
          e = expected_uv.pop_front();
          if (out_u_coord !== e.u || out_v_coord !== e.v || out_saturated !== e.sat) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch exp u=%h v=%h sat=%b got u=%h v=%h sat=%b",
                       e.u, e.v, e.sat, out_u_coord, out_v_coord, out_saturated);
          end
        end
      end
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: errors");
        $finish;
      end else idle_cycles <= idle_cycles + 1;
    end
  end

  // vertex driver, bursts with random gaps
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (n_popped < n_accepted) begin
      void'(pending_verts.pop_front());
      n_popped = n_popped + 1;
    end
    if (!rst_n || gap_left > 0 || pending_verts.size() == 0) begin
      if (gap_left > 0) gap_left = gap_left - 1;
      start <= 1'b0;
    end else begin
      start <= 1'b1;
      in_pos_x <= pending_verts[0].x;
      in_pos_y <= pending_verts[0].y;
      in_pos_z <= pending_verts[0].z;
      in_normal_x <= pending_verts[0].nx;
      in_normal_y <= pending_verts[0].ny;
      in_normal_z <= pending_verts[0].nz;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      end else begin
        burst_left = burst_left - 1;
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      tcg_pkg::REG_MODE:     mode_m = data[1:0];
      tcg_pkg::REG_SCALE_U:  su_m = longint'($signed(data));
      tcg_pkg::REG_SCALE_V:  sv_m = longint'($signed(data));
      tcg_pkg::REG_OFFSET_U: ou_m = longint'($signed(data));
      tcg_pkg::REG_OFFSET_V: ov_m = longint'($signed(data));
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [1:0] md, logic [31:0] su, logic [31:0] sv,
                          logic [31:0] ou, logic [31:0] ov);
    cfg_write(tcg_pkg::REG_MODE, {30'd0, md});
    cfg_write(tcg_pkg::REG_SCALE_U, su);
    cfg_write(tcg_pkg::REG_SCALE_V, sv);
    cfg_write(tcg_pkg::REG_OFFSET_U, ou);
    cfg_write(tcg_pkg::REG_OFFSET_V, ov);
  endtask

  function automatic logic [31:0] pick_coord();
    int k;
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'($signed($urandom_range(0, 4 * 6554)) - 2 * 6554);
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'd0;
          3: return 32'd1;
          default: return 32'hffffffff;
        endcase
      end
      default: begin
        k = $urandom_range(1, 31);
        return ($urandom & ((32'd1 << k) - 1)) ^ ({32{$urandom_range(0, 1) == 1}});
      end
    endcase
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t vx;
    logic [15:0] m;
    vx.x = pick_coord();
    vx.y = pick_coord();
    vx.z = pick_coord();
    if ($urandom_range(0, 7) == 0) begin
      vx.x = 32'($signed($urandom_range(0, 2 * 6553)) - 6553);
      vx.z = 32'($signed($urandom_range(0, 2 * 6553)) - 6553);
    end
    vx.nx = $urandom; vx.ny = $urandom; vx.nz = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      // tie on magnitude, sign chosen per axis
      m = ($urandom_range(0, 5) == 0) ? 16'h8000 : 16'($urandom);
      vx.nx = $urandom_range(0, 1) ? m : -m;
      vx.ny = $urandom_range(0, 1) ? m : -m;
      if ($urandom_range(0, 1)) vx.nz = $urandom_range(0, 1) ? m : -m;
    end
    return vx;
  endfunction

  task automatic run_phase(int n_rand);
    for (int i = 0; i < n_rand; i++) pending_verts.push_back(rand_vertex());
    wait (pending_verts.size() == 0 && expected_uv.size() == 0);
    repeat (tcg_pkg::LATENCY + 5) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration, planar extremes
    pending_verts.push_back('{32'h7fffffff, 32'h80000000, 32'd0, 16'd0, 16'd0, 16'd0});
    pending_verts.push_back('{32'h80000000, 32'h7fffffff, 32'hffffffff,
                              16'h7fff, 16'h8000, 16'hffff});
    pending_verts.push_back('{32'd0, 32'd0, 32'd0, 16'h8000, 16'h8000, 16'h8000});
    run_phase(110);

    set_regs(tcg_pkg::MODE_SPHERICAL, 32'd65536, 32'd65536, 32'd0, 32'd0);
    pending_verts.push_back('{32'd0, 32'd100, 32'd0, 16'd0, 16'd0, 16'd0});
    pending_verts.push_back('{32'hffffe667, 32'hffff0000, 32'd6553, 16'd0, 16'd0, 16'd0});
    pending_verts.push_back('{32'd6554, 32'd0, 32'd0, 16'd0, 16'd0, 16'd0});
    pending_verts.push_back('{32'h7fffffff, 32'h80000000, 32'd0, 16'd0, 16'd0, 16'd0});
    pending_verts.push_back('{32'h80000000, 32'h7fffffff, 32'h80000000, 16'd0, 16'd0, 16'd0});
    pending_verts.push_back('{32'd65536, 32'd0, 32'hffff0000, 16'd0, 16'd0, 16'd0});
    pending_verts.push_back('{32'd0, 32'h80000000, 32'd65536, 16'd0, 16'd0, 16'd0});
    run_phase(110);

    set_regs(tcg_pkg::MODE_BOX, 32'd65536, 32'd65536, 32'd0, 32'd0);
    cfg_write(REG_UNUSED, $urandom);
    pending_verts.push_back('{32'd5, 32'hfffffff9, 32'hfffffff3, 16'd100, 16'd100, 16'd100});
    pending_verts.push_back('{32'd5, 32'hfffffff9, 32'hfffffff3, 16'd100, 16'd50, 16'hff9c});
    pending_verts.push_back('{32'd5, 32'hfffffff9, 32'hfffffff3, 16'hff9c, 16'd100, 16'd50});
    pending_verts.push_back('{32'd5, 32'hfffffff9, 32'hfffffff3, 16'd1, 16'd2, 16'd3});
    pending_verts.push_back('{32'd5, 32'hfffffff9, 32'hfffffff3, 16'd1, 16'd3, 16'd2});
    pending_verts.push_back('{32'h80000000, 32'h80000000, 32'h80000000,
                              16'h7fff, 16'h7fff, 16'h8000});
    pending_verts.push_back('{32'h7fffffff, 32'h80000000, 32'h80000000,
                              16'h8000, 16'h7fff, 16'h7fff});
    run_phase(110);

    set_regs(MODE_PLANAR_ALT, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
    pending_verts.push_back('{32'h7fffffff, 32'h7fffffff, 32'd0, 16'd0, 16'd0, 16'd0});
    pending_verts.push_back('{32'h80000000, 32'h80000000, 32'd0, 16'd0, 16'd0, 16'd0});
    run_phase(110);

    set_regs(tcg_pkg::MODE_SPHERICAL, $urandom_range(0, 1 << 20), $urandom, $urandom,
             $urandom);
    run_phase(110);
    set_regs(tcg_pkg::MODE_BOX, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    run_phase(110);
    set_regs(MODE_PLANAR, $urandom, $urandom, $urandom, $urandom);
    run_phase(110);
    set_regs(tcg_pkg::MODE_SPHERICAL, 32'd0, 32'd0, 32'h80000000, 32'h7fffffff);
    run_phase(100);
    set_regs(tcg_pkg::MODE_BOX, $urandom, $urandom_range(0, 1 << 18), $urandom, $urandom);
    run_phase(110);
    set_regs(tcg_pkg::MODE_SPHERICAL, 32'hfffe0000, 32'h00028000, 32'd0, 32'd0);
    run_phase(60);

    if (n_errors == 0 && expected_uv.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

### files.f
hw/rtl/tcg_pkg.sv
hw/rtl/tcg_isqrt.sv
hw/rtl/tcg_cordic.sv
hw/rtl/tcg_map.sv
hw/rtl/uv_texture_coordinate_generator.sv
hw/rtl/tcg_checker.sv
dv/tb.sv
